FILE: rtl/itrp_pkg.sv
// ----------------------------------------------------------------------------
// itrp_pkg
// Types and constants shared by the interrupt table record parser.
// ----------------------------------------------------------------------------
package itrp_pkg;

  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,
    CMD_START  = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_PROC    = 3'd0,
    KIND_IOAPIC  = 3'd1,
    KIND_OVR     = 3'd2,
    KIND_NMI     = 3'd3,
    KIND_UNKNOWN = 3'd4,
    KIND_END     = 3'd5,
    KIND_LOOKUP  = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_e;

  localparam logic [31:0] HeaderBytes = 32'd44;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic [7:0] irq;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  first_id;
    logic [7:0]  second_id;
    logic [31:0] address_or_gsi;
    logic [31:0] flags_or_base;
    logic        saved;
    logic        override_hit;
    logic        checksum_ok;
  } out_word_t;

  // Control between the sequencer and the override store scanner.
  typedef struct packed {
    logic       start;
    logic [7:0] irq;
  } scan_req_t;

  typedef struct packed {
    logic        done;
    logic        hit;
    logic [31:0] gsi;
  } scan_rsp_t;

endpackage

FILE: rtl/itrp_override_store.sv
// ----------------------------------------------------------------------------
// itrp_override_store
// Override entry memory with an entry-per-cycle scan for IRQ lookups.
// ----------------------------------------------------------------------------
module itrp_override_store #(
  parameter int unsigned MaxOverrides = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [$clog2(MaxOverrides+1)-1:0] wr_idx_i,
  input  logic [39:0]         wr_data_i,
  input  logic [$clog2(MaxOverrides+1)-1:0] count_i,
  input  itrp_pkg::scan_req_t req_i,
  output itrp_pkg::scan_rsp_t rsp_o
);

  localparam int unsigned CW = $clog2(MaxOverrides + 1);
  localparam int unsigned AW = (MaxOverrides > 1) ? $clog2(MaxOverrides) : 1;

  logic [39:0]   mem [MaxOverrides];
  logic [39:0]   rd_q;
  logic [CW-1:0] idx_q, idx_d;
  logic          busy_q, busy_d, rdv_q, rdv_d;
  logic [7:0]    irq_q;
  logic          done_q, done_d, hit_q, hit_d;
  logic [31:0]   gsi_q, gsi_d;
  logic [AW-1:0] waddr, raddr;

  assign waddr = wr_idx_i[AW-1:0];
  assign raddr = idx_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[waddr] <= wr_data_i;
    rd_q <= mem[raddr];
  end

  // One entry is read per cycle; the compare sees it in the cycle after the read.
  always_comb begin
    idx_d  = idx_q;
    busy_d = busy_q;
    rdv_d  = 1'b0;
    done_d = 1'b0;
    hit_d  = hit_q;
    gsi_d  = gsi_q;
    if (req_i.start) begin
      idx_d  = '0;
      busy_d = 1'b1;
      hit_d  = 1'b0;
      gsi_d  = {24'd0, req_i.irq};
    end else if (busy_q) begin
      if (rdv_q && rd_q[7:0] == irq_q) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        hit_d  = 1'b1;
        gsi_d  = rd_q[39:8];
      end else if (idx_q >= count_i || idx_q == CW'(MaxOverrides)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        rdv_d = 1'b1;
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      busy_q <= 1'b0;
      rdv_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      busy_q <= busy_d;
      rdv_q  <= rdv_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
    gsi_q <= gsi_d;
    if (req_i.start) irq_q <= req_i.irq;
  end

  assign rsp_o = '{done: done_q, hit: hit_q, gsi: gsi_q};

endmodule

FILE: rtl/interrupt_table_record_parser.sv
// ----------------------------------------------------------------------------
// interrupt_table_record_parser
// Byte-serial parser for an interrupt controller description table.
// ----------------------------------------------------------------------------
// Table bytes and start commands are taken one a cycle while no lookup runs and
// the output is not held, and give their word, if any, in the output register
// on the following cycle. An IRQ lookup scans the override memory one entry a
// cycle through its single read port. A pending word on the output blocks the
// input until it is taken.
module interrupt_table_record_parser #(
  parameter int unsigned MAX_PROCESSORS       = 64,
  parameter int unsigned MAX_IO_CONTROLLERS   = 8,
  parameter int unsigned MAX_OVERRIDES        = 16,
  parameter int unsigned RECORD_CAPTURE_BYTES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  itrp_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output itrp_pkg::out_word_t  out_data_o
);

  localparam int unsigned PW = $clog2(MAX_PROCESSORS + 1);
  localparam int unsigned IW = $clog2(MAX_IO_CONTROLLERS + 1);
  localparam int unsigned OW = $clog2(MAX_OVERRIDES + 1);
  localparam int unsigned RCB = RECORD_CAPTURE_BYTES;
  localparam int unsigned RW = $clog2(RCB);

  itrp_pkg::state_e state_q, state_d;
  logic [31:0] pos_q, pos_d, len_q, len_d, base_q, base_d, tflags_q, tflags_d;
  logic [7:0]  sum_q, sum_d, roff_q, roff_d, rlen_q, rlen_d;
  logic [7:0]  rec_q [RCB];
  logic        stop_q, stop_d, endp_q, endp_d;
  logic [PW-1:0] pcnt_q, pcnt_d;
  logic [IW-1:0] icnt_q, icnt_d;
  logic [OW-1:0] ocnt_q, ocnt_d;
  logic        rec_we;
  logic [RW-1:0] rec_wa;
  logic [7:0]  rec_wd;
  logic        ovr_we;
  logic [39:0] ovr_wd;
  itrp_pkg::out_word_t ow_q, ow_d;
  logic        ov_q, ov_d;
  itrp_pkg::scan_req_t sreq;
  itrp_pkg::scan_rsp_t srsp;

  logic        accept;
  logic [7:0]  d;
  logic [31:0] pn;
  logic        last, done_now, produced;
  logic [7:0]  rb [RCB];

  assign accept     = in_valid_i && !in_stall_o;
  // A word that leaves this cycle frees the output register for the next one.
  assign in_stall_o = (state_q != itrp_pkg::ST_IDLE) || (ov_q && out_stall_i);
  assign d          = in_data_i.data_byte;

  // Record view with the current byte folded in at its offset.
  always_comb begin
    for (int k = 0; k < RCB; k++) begin
      rb[k] = rec_q[k];
      if (roff_q == 8'(k)) rb[k] = d;
    end
  end

  function automatic logic [7:0] rbyte(input logic [7:0] v [RCB], input int unsigned i);
    return (i < RCB) ? v[i] : 8'd0;
  endfunction

  always_comb begin
    logic [7:0] typ;
    logic [7:0] rl;
    logic       dec;
    typ = 8'd0;
    rl  = 8'd0;
    dec = 1'b0;
    state_d = state_q;
    pos_d = pos_q; len_d = len_q; base_d = base_q; tflags_d = tflags_q;
    sum_d = sum_q; roff_d = roff_q; rlen_d = rlen_q; stop_d = stop_q;
    endp_d = endp_q; pcnt_d = pcnt_q; icnt_d = icnt_q; ocnt_d = ocnt_q;
    rec_we = 1'b0; rec_wa = roff_q[RW-1:0]; rec_wd = d;
    ovr_we = 1'b0; ovr_wd = '0;
    ow_d = '0; ov_d = ov_q && out_stall_i;
    sreq = '{start: 1'b0, irq: in_data_i.irq};
    pn = pos_q + 32'd1;
    last = 1'b0; done_now = 1'b0; produced = 1'b0;
    if (ov_q && out_stall_i) ow_d = ow_q;

    case (state_q)
      itrp_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_data_i.command)
            itrp_pkg::CMD_START: begin
              pos_d = '0; len_d = '0; base_d = '0; tflags_d = '0; sum_d = '0;
              roff_d = '0; rlen_d = '0; stop_d = 1'b0; endp_d = 1'b0;
              pcnt_d = '0; icnt_d = '0; ocnt_d = '0;
            end
            itrp_pkg::CMD_LOOKUP: begin
              sreq.start = 1'b1;
              state_d = itrp_pkg::ST_SCAN;
            end
            itrp_pkg::CMD_BYTE: begin
              done_now = (pos_q >= itrp_pkg::HeaderBytes) && (pos_q >= len_q);
              if (endp_q) begin
                endp_d = 1'b0;
                ow_d = '{kind: itrp_pkg::KIND_END, first_id: '0, second_id: '0,
                         address_or_gsi: base_q, flags_or_base: tflags_q,
                         saved: 1'b0, override_hit: 1'b0,
                         checksum_ok: (sum_q == 8'd0)};
                ov_d = 1'b1;
              end else if (!done_now) begin
                sum_d = sum_q + d;
                if (pos_q >= 32'd4 && pos_q < 32'd8)
                  len_d[8*pos_q[1:0] +: 8] = d;
                else if (pos_q >= 32'd36 && pos_q < 32'd40)
                  base_d[8*pos_q[1:0] +: 8] = d;
                else if (pos_q >= 32'd40 && pos_q < 32'd44)
                  tflags_d[8*pos_q[1:0] +: 8] = d;
                pos_d = pn;
                last = (pn >= itrp_pkg::HeaderBytes) && (pn >= len_d);
                if (pos_q >= itrp_pkg::HeaderBytes && !stop_q) begin
                  if (roff_q < 8'(RCB)) rec_we = 1'b1;
                  if (roff_q == 8'd0) begin
                    roff_d = 8'd1;
                    if (last) begin produced = 1'b1; typ = d; rl = 8'd0; end
                  end else if (roff_q == 8'd1) begin
                    if (d == 8'd0) begin
                      stop_d = 1'b1; roff_d = 8'd0;
                    end else if (d == 8'd1) begin
                      produced = 1'b1; typ = rec_q[0]; rl = 8'd1;
                      rec_wa = '0; roff_d = 8'd1;
                    end else begin
                      rlen_d = d; roff_d = 8'd2;
                      if (d == 8'd2) begin
                        roff_d = 8'd0; dec = 1'b1;
                      end else if (last) begin
                        produced = 1'b1; typ = rec_q[0]; rl = d;
                      end
                    end
                  end else begin
                    roff_d = roff_q + 8'd1;
                    if ({1'b0, roff_q} + 9'd1 >= {1'b0, rlen_q}) begin
                      roff_d = 8'd0; dec = 1'b1;
                    end else if (last) begin
                      produced = 1'b1; typ = rec_q[0]; rl = rlen_q;
                    end
                  end
                end
                if (dec) begin
                  produced = 1'b1;
                  typ = rb[0];
                  rl = rlen_d;
                  if (typ == 8'd0 && rl >= 8'd8) begin
                    ow_d.kind = itrp_pkg::KIND_PROC;
                    ow_d.first_id = rbyte(rb, 3); ow_d.second_id = rbyte(rb, 2);
                    ow_d.flags_or_base = {rbyte(rb, 7), rbyte(rb, 6),
                                          rbyte(rb, 5), rbyte(rb, 4)};
                    if (pcnt_q < PW'(MAX_PROCESSORS)) begin
                      ow_d.saved = 1'b1; pcnt_d = pcnt_q + 1'b1;
                    end
                  end else if (typ == 8'd1 && rl >= 8'd12) begin
                    ow_d.kind = itrp_pkg::KIND_IOAPIC;
                    ow_d.first_id = rbyte(rb, 2);
                    ow_d.address_or_gsi = {rbyte(rb, 7), rbyte(rb, 6),
                                           rbyte(rb, 5), rbyte(rb, 4)};
                    ow_d.flags_or_base = {rbyte(rb, 11), rbyte(rb, 10),
                                          rbyte(rb, 9), rbyte(rb, 8)};
                    if (icnt_q < IW'(MAX_IO_CONTROLLERS)) begin
                      ow_d.saved = 1'b1; icnt_d = icnt_q + 1'b1;
                    end
                  end else if (typ == 8'd2 && rl >= 8'd10) begin
                    ow_d.kind = itrp_pkg::KIND_OVR;
                    ow_d.first_id = rbyte(rb, 2); ow_d.second_id = rbyte(rb, 3);
                    ow_d.address_or_gsi = {rbyte(rb, 7), rbyte(rb, 6),
                                           rbyte(rb, 5), rbyte(rb, 4)};
                    ow_d.flags_or_base = {16'd0, rbyte(rb, 9), rbyte(rb, 8)};
                    if (ocnt_q < OW'(MAX_OVERRIDES)) begin
                      ow_d.saved = 1'b1; ocnt_d = ocnt_q + 1'b1;
                      ovr_we = 1'b1;
                      ovr_wd = {ow_d.address_or_gsi, rbyte(rb, 3)};
                    end
                  end else if (typ == 8'd4 && rl >= 8'd6) begin
                    ow_d.kind = itrp_pkg::KIND_NMI;
                    ow_d.first_id = rbyte(rb, 2); ow_d.second_id = rbyte(rb, 5);
                    ow_d.flags_or_base = {16'd0, rbyte(rb, 4), rbyte(rb, 3)};
                  end else begin
                    ow_d.kind = itrp_pkg::KIND_UNKNOWN;
                    ow_d.first_id = typ; ow_d.second_id = rl;
                  end
                end else if (produced) begin
                  ow_d.kind = itrp_pkg::KIND_UNKNOWN;
                  ow_d.first_id = typ; ow_d.second_id = rl;
                end
                if (produced) begin
                  ov_d = 1'b1;
                  if (last) endp_d = 1'b1;
                end else if (last) begin
                  ow_d = '{kind: itrp_pkg::KIND_END, first_id: '0, second_id: '0,
                           address_or_gsi: base_d, flags_or_base: tflags_d,
                           saved: 1'b0, override_hit: 1'b0,
                           checksum_ok: (sum_d == 8'd0)};
                  ov_d = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      itrp_pkg::ST_SCAN: begin
        if (srsp.done) begin
          ow_d = '0;
          ow_d.kind = itrp_pkg::KIND_LOOKUP;
          ow_d.address_or_gsi = srsp.gsi;
          ow_d.override_hit = srsp.hit;
          ov_d = 1'b1;
          state_d = itrp_pkg::ST_IDLE;
        end
      end
      default: state_d = itrp_pkg::ST_IDLE;
    endcase
  end

  itrp_override_store #(.MaxOverrides(MAX_OVERRIDES)) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (ovr_we),
    .wr_idx_i (ocnt_q),
    .wr_data_i(ovr_wd),
    .count_i  (ocnt_q),
    .req_i    (sreq),
    .rsp_o    (srsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itrp_pkg::ST_IDLE;
      pos_q <= '0; len_q <= '0; base_q <= '0; tflags_q <= '0; sum_q <= '0;
      roff_q <= '0; rlen_q <= '0; stop_q <= 1'b0; endp_q <= 1'b0;
      pcnt_q <= '0; icnt_q <= '0; ocnt_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q <= pos_d; len_q <= len_d; base_q <= base_d; tflags_q <= tflags_d;
      sum_q <= sum_d; roff_q <= roff_d; rlen_q <= rlen_d; stop_q <= stop_d;
      endp_q <= endp_d; pcnt_q <= pcnt_d; icnt_q <= icnt_d; ocnt_q <= ocnt_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ow_q <= ow_d;
    if (rec_we) rec_q[rec_wa] <= rec_wd;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = ow_q;

  // A word held by the receiver blocks new input.
  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o) else $error("input taken over a held word");
  // Counts never pass their capacity.
  a_ocnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= OW'(MAX_OVERRIDES)) else $error("override count overflow");
  // A lookup ends with its answer and nothing else.
  a_scan_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == itrp_pkg::ST_SCAN && srsp.done) |=>
      (out_valid_o && out_data_o.kind == itrp_pkg::KIND_LOOKUP))
    else $error("lookup answer missing");

endmodule
